>>> hw/rtl/sequence_sorter_top_macros.svh
// ----------------------------------------------------------------------------
// Sequence sorter assertion macros
// Concurrent assertion helpers used by the sequence sorter top level.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_SORTER_TOP_MACROS_SVH
`define SEQUENCE_SORTER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/ss_pkg.sv
// ----------------------------------------------------------------------------
// Sequence sorter package
// Shared sizes, payload and memory port types, and sequencer states.
// ----------------------------------------------------------------------------
package ss_pkg;

   localparam int DEPTH   = 64;
   localparam int DATA_W  = 32;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int ENTRY_W = 2 * CNT_W;

   typedef struct packed {
      logic signed [DATA_W-1:0] value;
      logic                     last;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] value_res;
      logic                     last_res;
   } rsp_payload_type;

   typedef struct packed {
      logic                     we;
      logic [IDX_W-1:0]         waddr;
      logic signed [DATA_W-1:0] wdata;
      logic                     re;
      logic [IDX_W-1:0]         raddr_a;
      logic [IDX_W-1:0]         raddr_b;
   } elem_req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] rdata_a;
      logic signed [DATA_W-1:0] rdata_b;
   } elem_rsp_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [ENTRY_W-1:0] wdata;
      logic               re;
      logic [IDX_W-1:0]   raddr;
   } stack_req_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_SORT_INIT,
      ST_POP,
      ST_POP_WAIT,
      ST_PIVOT_WAIT,
      ST_SCAN_ISSUE,
      ST_SCAN_CMP,
      ST_SCAN_SWAP,
      ST_FINAL_A,
      ST_FINAL_B,
      ST_PUSH_HI,
      ST_PUSH_LO,
      ST_EMIT_RD,
      ST_EMIT_WAIT,
      ST_EMIT_HOLD
   } state_type;

endpackage

>>> hw/rtl/sequence_sorter_top.sv
// Loading takes one request per cycle; the block stalls requests after the last one.
// Each partition works through the single comparator and the one write port of the
// element store; emitting reads, registers and then holds each result until it is taken.
// Synchronous active-high reset empties the store and stack and returns to loading.
// ----------------------------------------------------------------------------
// Sequence sorter top level
// Stores a flagged sequence, quicksorts it in place and emits it ascending.
// ----------------------------------------------------------------------------
`include "sequence_sorter_top_macros.svh"

module sequence_sorter_top (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ss_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ss_pkg::rsp_payload_type rsp_payload
);
   import ss_pkg::*;

   elem_req_type       elem_req;
   elem_rsp_type       elem_rsp;
   stack_req_type      stack_req;
   logic [ENTRY_W-1:0] stack_rdata;

   ss_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .elem_req    (elem_req),
      .elem_rsp    (elem_rsp),
      .stack_req   (stack_req),
      .stack_rdata (stack_rdata)
   );

   ss_elem_store u_elem_store (
      .clock    (clock),
      .elem_req (elem_req),
      .elem_rsp (elem_rsp)
   );

   ss_range_stack u_range_stack (
      .clock       (clock),
      .stack_req   (stack_req),
      .stack_rdata (stack_rdata)
   );

   // No result may be offered while the block is still taking requests.
   `SS_ASSERT_SAME(a_no_rsp_while_loading, clock, reset, !req_stall, !rsp_valid, "result offered while loading")
   // The last request of a sequence starts the sort, so requests stall next.
   `SS_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && !req_stall && req_payload.last, req_stall, "request taken after last")
   // Once the final result is taken the block loads again.
   `SS_ASSERT_NEXT(a_load_after_final, clock, reset, rsp_valid && !rsp_stall && rsp_payload.last_res, !req_stall && !rsp_valid, "no return to loading")

endmodule

>>> hw/rtl/ss_elem_store.sv
// ----------------------------------------------------------------------------
// Sequence sorter element store
// Element memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module ss_elem_store (
   input  logic                 clock,
   input  ss_pkg::elem_req_type elem_req,
   output ss_pkg::elem_rsp_type elem_rsp
);
   import ss_pkg::*;

   logic signed [DATA_W-1:0] store_ff [DEPTH];
   logic signed [DATA_W-1:0] rdata_a_ff;
   logic signed [DATA_W-1:0] rdata_b_ff;

   // Read data holds until the next read, so a swap can write it back later.
   always_ff @(posedge clock) begin
      if (elem_req.we) begin
         store_ff[elem_req.waddr] <= elem_req.wdata;
      end
      if (elem_req.re) begin
         rdata_a_ff <= store_ff[elem_req.raddr_a];
         rdata_b_ff <= store_ff[elem_req.raddr_b];
      end
   end

   assign elem_rsp.rdata_a = rdata_a_ff;
   assign elem_rsp.rdata_b = rdata_b_ff;

endmodule

>>> hw/rtl/ss_range_stack.sv
// ----------------------------------------------------------------------------
// Sequence sorter range stack
// Memory of pending index ranges, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ss_range_stack (
   input  logic                          clock,
   input  ss_pkg::stack_req_type         stack_req,
   output logic [ss_pkg::ENTRY_W-1:0]    stack_rdata
);
   import ss_pkg::*;

   logic [ENTRY_W-1:0] stack_ff [DEPTH];
   logic [ENTRY_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (stack_req.we) begin
         stack_ff[stack_req.waddr] <= stack_req.wdata;
      end
      if (stack_req.re) begin
         rdata_ff <= stack_ff[stack_req.raddr];
      end
   end

   assign stack_rdata = rdata_ff;

endmodule

>>> hw/rtl/ss_seq.sv
// ----------------------------------------------------------------------------
// Sequence sorter sequencer
// Loads requests, runs Lomuto partitions with one shared comparator, emits.
// ----------------------------------------------------------------------------
module ss_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ss_pkg::req_payload_type req_payload,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output ss_pkg::rsp_payload_type rsp_payload,
   output ss_pkg::elem_req_type    elem_req,
   input  ss_pkg::elem_rsp_type    elem_rsp,
   output ss_pkg::stack_req_type   stack_req,
   input  logic [ss_pkg::ENTRY_W-1:0] stack_rdata
);
   import ss_pkg::*;

   state_type                state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         top_ff, top_in;
   logic [CNT_W-1:0]         lo_ff, lo_in;
   logic [CNT_W-1:0]         hi_ff, hi_in;
   logic [CNT_W-1:0]         j_ff, j_in;
   logic [CNT_W-1:0]         slot_ff, slot_in;
   logic signed [DATA_W-1:0] pivot_ff, pivot_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   logic [CNT_W-1:0] ent_lo;
   logic [CNT_W-1:0] ent_hi;
   logic [CNT_W-1:0] ent_hi_m1;
   logic             ent_ok;
   logic [CNT_W-1:0] j_p1;
   logic [CNT_W-1:0] slot_p1;
   logic [CNT_W-1:0] hi_m1;
   logic             is_less;
   logic             stack_room;

   assign ent_lo     = stack_rdata[ENTRY_W-1:CNT_W];
   assign ent_hi     = stack_rdata[CNT_W-1:0];
   assign ent_hi_m1  = ent_hi - CNT_W'(1);
   assign ent_ok     = (ent_hi <= count_ff) && (ent_lo < ent_hi)
                       && ((ent_hi - ent_lo) >= CNT_W'(2));
   assign j_p1       = j_ff + CNT_W'(1);
   assign slot_p1    = slot_ff + CNT_W'(1);
   assign hi_m1      = hi_ff - CNT_W'(1);
   assign stack_room = top_ff < CNT_W'(DEPTH);

   // The one comparator shared by every scan step of every partition.
   assign is_less = elem_rsp.rdata_a < pivot_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_payload.last) begin
               state_in = ST_SORT_INIT;
            end
         end
         ST_SORT_INIT: state_in = ST_POP;
         ST_POP: begin
            state_in = (top_ff == '0) ? ST_EMIT_RD : ST_POP_WAIT;
         end
         ST_POP_WAIT: state_in = ent_ok ? ST_PIVOT_WAIT : ST_POP;
         ST_PIVOT_WAIT: state_in = ST_SCAN_ISSUE;
         ST_SCAN_ISSUE: begin
            state_in = (j_p1 < hi_ff) ? ST_SCAN_CMP : ST_FINAL_A;
         end
         ST_SCAN_CMP: begin
            state_in = (is_less && (slot_ff != j_ff)) ? ST_SCAN_SWAP : ST_SCAN_ISSUE;
         end
         ST_SCAN_SWAP: state_in = ST_SCAN_ISSUE;
         ST_FINAL_A: state_in = ST_FINAL_B;
         ST_FINAL_B: state_in = ST_PUSH_HI;
         ST_PUSH_HI: state_in = ST_PUSH_LO;
         ST_PUSH_LO: state_in = ST_POP;
         ST_EMIT_RD: state_in = ST_EMIT_WAIT;
         ST_EMIT_WAIT: state_in = ST_EMIT_HOLD;
         ST_EMIT_HOLD: begin
            if (!rsp_stall) begin
               state_in = rsp_payload_ff.last_res ? ST_LOAD : ST_EMIT_RD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      count_in       = count_ff;
      top_in         = top_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      j_in           = j_ff;
      slot_in        = slot_ff;
      pivot_in       = pivot_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      elem_req       = '0;
      stack_req      = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && (count_ff < CNT_W'(DEPTH))) begin
               elem_req.we    = 1'b1;
               elem_req.waddr = count_ff[IDX_W-1:0];
               elem_req.wdata = req_payload.value;
               count_in       = count_ff + CNT_W'(1);
            end
         end
         ST_SORT_INIT: begin
            top_in = '0;
            if (count_ff >= CNT_W'(2)) begin
               stack_req.we    = 1'b1;
               stack_req.waddr = '0;
               stack_req.wdata = {CNT_W'(0), count_ff};
               top_in          = CNT_W'(1);
            end
         end
         ST_POP: begin
            j_in = '0;
            if (top_ff != '0) begin
               stack_req.re    = 1'b1;
               stack_req.raddr = top_ff[IDX_W-1:0] - IDX_W'(1);
               top_in          = top_ff - CNT_W'(1);
            end
         end
         ST_POP_WAIT: begin
            lo_in            = ent_lo;
            hi_in            = ent_hi;
            j_in             = ent_lo;
            slot_in          = ent_lo;
            elem_req.re      = ent_ok;
            elem_req.raddr_a = ent_hi_m1[IDX_W-1:0];
            elem_req.raddr_b = ent_hi_m1[IDX_W-1:0];
         end
         ST_PIVOT_WAIT: pivot_in = elem_rsp.rdata_a;
         ST_SCAN_ISSUE: begin
            elem_req.re = 1'b1;
            if (j_p1 < hi_ff) begin
               elem_req.raddr_a = j_ff[IDX_W-1:0];
               elem_req.raddr_b = slot_ff[IDX_W-1:0];
            end else begin
               elem_req.raddr_a = slot_ff[IDX_W-1:0];
               elem_req.raddr_b = hi_m1[IDX_W-1:0];
            end
         end
         ST_SCAN_CMP: begin
            if (is_less) begin
               slot_in = slot_p1;
               if (slot_ff != j_ff) begin
                  elem_req.we    = 1'b1;
                  elem_req.waddr = slot_ff[IDX_W-1:0];
                  elem_req.wdata = elem_rsp.rdata_a;
               end else begin
                  j_in = j_p1;
               end
            end else begin
               j_in = j_p1;
            end
         end
         ST_SCAN_SWAP: begin
            // The old slot value goes to where the smaller one came from.
            elem_req.we    = 1'b1;
            elem_req.waddr = j_ff[IDX_W-1:0];
            elem_req.wdata = elem_rsp.rdata_b;
            j_in           = j_p1;
         end
         ST_FINAL_A: begin
            elem_req.we    = 1'b1;
            elem_req.waddr = slot_ff[IDX_W-1:0];
            elem_req.wdata = elem_rsp.rdata_b;
         end
         ST_FINAL_B: begin
            elem_req.we    = 1'b1;
            elem_req.waddr = hi_m1[IDX_W-1:0];
            elem_req.wdata = elem_rsp.rdata_a;
         end
         ST_PUSH_HI: begin
            if (((hi_ff - slot_p1) >= CNT_W'(2)) && stack_room) begin
               stack_req.we    = 1'b1;
               stack_req.waddr = top_ff[IDX_W-1:0];
               stack_req.wdata = {slot_p1, hi_ff};
               top_in          = top_ff + CNT_W'(1);
            end
         end
         ST_PUSH_LO: begin
            if (((slot_ff - lo_ff) >= CNT_W'(2)) && stack_room) begin
               stack_req.we    = 1'b1;
               stack_req.waddr = top_ff[IDX_W-1:0];
               stack_req.wdata = {lo_ff, slot_ff};
               top_in          = top_ff + CNT_W'(1);
            end
         end
         ST_EMIT_RD: begin
            elem_req.re      = 1'b1;
            elem_req.raddr_a = j_ff[IDX_W-1:0];
            elem_req.raddr_b = j_ff[IDX_W-1:0];
         end
         ST_EMIT_WAIT: begin
            rsp_valid_in             = 1'b1;
            rsp_payload_in.value_res = elem_rsp.rdata_a;
            rsp_payload_in.last_res  = (j_p1 == count_ff);
         end
         ST_EMIT_HOLD: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               j_in         = j_p1;
               if (rsp_payload_ff.last_res) begin
                  count_in = '0;
                  top_in   = '0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      j_ff           <= j_in;
      slot_ff        <= slot_in;
      pivot_ff       <= pivot_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_stall   = (state_ff != ST_LOAD);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

>>> test/tb_sequence_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence sorter testbench
// Sends flagged sequences of signed values and checks that every sorted
// result comes back in ascending order. The expected results come from a
// Lomuto quicksort model in the bench. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_sequence_sorter_top;
   import ss_pkg::*;

   localparam logic signed [DATA_W-1:0] MOST_NEG = 32'h8000_0000;
   localparam logic signed [DATA_W-1:0] MOST_POS = 32'h7FFF_FFFF;
   localparam int MAX_WAIT   = 17;
   localparam int TAIL_WAIT  = 40;
   localparam int ITEM_GOAL  = 170;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b1;
   rsp_payload_type rsp_payload;

   logic                     idling = 1'b1;
   logic signed [DATA_W-1:0] stored_values [DEPTH];
   int                       stored_count = 0;
   rsp_payload_type          sorted_expect[$];
   int                       rsp_hold = 0;
   int                       requests_sent = 0;
   int                       sequences_sent = 0;
   int                       results_checked = 0;
   int                       error_count = 0;

   sequence_sorter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #2 clock = ~clock;

   // In-place Lomuto quicksort of the stored values, pivot at the end of each range.
   function automatic void sort_stored();
      int lo_stack[$];
      int hi_stack[$];
      int lo;
      int hi;
      int slot;
      int j;
      logic signed [DATA_W-1:0] pivot;
      logic signed [DATA_W-1:0] tmp;
      if (stored_count >= 2) begin
         lo_stack.push_back(0);
         hi_stack.push_back(stored_count);
      end
      while (lo_stack.size() > 0) begin
         lo    = lo_stack.pop_back();
         hi    = hi_stack.pop_back();
         pivot = stored_values[hi-1];
         slot  = lo;
         for (j = lo; j < hi - 1; j++) begin
            if (stored_values[j] < pivot) begin
               tmp                 = stored_values[slot];
               stored_values[slot] = stored_values[j];
               stored_values[j]    = tmp;
               slot++;
            end
         end
         tmp                 = stored_values[slot];
         stored_values[slot] = stored_values[hi-1];
         stored_values[hi-1] = tmp;
         if (hi - (slot + 1) >= 2) begin
            lo_stack.push_back(slot + 1);
            hi_stack.push_back(hi);
         end
         if (slot - lo >= 2) begin
            lo_stack.push_back(lo);
            hi_stack.push_back(slot);
         end
      end
   endfunction

   // Stores an accepted request; a flagged one releases the whole sorted sequence.
   function automatic void take_request(input req_payload_type item);
      rsp_payload_type outcome;
      int k;
      if (stored_count < DEPTH) begin
         stored_values[stored_count] = item.value;
         stored_count++;
      end
      if (item.last) begin
         sort_stored();
         for (k = 0; k < stored_count; k++) begin
            outcome.value_res = stored_values[k];
            outcome.last_res  = (k == stored_count - 1);
            sorted_expect.push_back(outcome);
         end
         stored_count = 0;
         sequences_sent++;
      end
   endfunction

   function automatic logic signed [DATA_W-1:0] draw_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 3))
         0: v = $signed($urandom_range(0, 16)) - 8;
         1: v = $urandom_range(0, 1) ? MOST_NEG + $urandom_range(0, 2)
                                     : MOST_POS - $urandom_range(0, 2);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_value(input logic signed [DATA_W-1:0] v, input logic lst);
      int gap;
      req_payload_type item;
      gap        = idling ? $urandom_range(0, MAX_WAIT) : 0;
      item.value = v;
      item.last  = lst;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      requests_sent++;
      take_request(item);
   endtask

   task automatic send_sequence(input int len);
      int i;
      for (i = 0; i < len; i++) send_value(draw_value(), i == len - 1);
   endtask

   // Holds off the sender until every expected result has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (sorted_expect.size() > 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   task automatic test_extremes();
      send_value(MOST_POS, 1'b0);
      send_value(MOST_NEG, 1'b0);
      send_value(0, 1'b0);
      send_value(-1, 1'b0);
      send_value(1, 1'b0);
      send_value(MOST_NEG, 1'b0);
      send_value(MOST_POS, 1'b0);
      send_value(32'h5555_5555, 1'b0);
      send_value(32'hAAAA_AAAA, 1'b0);
      send_value(0, 1'b1);
   endtask

   task automatic test_single_items();
      send_value(-5, 1'b1);
      send_value(MOST_NEG, 1'b1);
   endtask

   // Already sorted, reversed and repeated input is the worst case for a last-element pivot.
   task automatic test_ordered_runs();
      int i;
      for (i = 0; i < 5; i++) send_value(i * 3 - 6, i == 4);
      for (i = 0; i < 5; i++) send_value(100 - i * 50, i == 4);
      for (i = 0; i < 4; i++) send_value(7, i == 3);
   endtask

   // More values than the store holds: the surplus, the flagged one included, is dropped.
   task automatic test_store_overflow();
      send_sequence(DEPTH + 2);
   endtask

   task automatic test_random_sequences(input int goal);
      while (requests_sent < goal) send_sequence($urandom_range(1, 12));
   endtask

   // Result side: random stall after each accepted result, compared in order.
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (sorted_expect.size() == 0) begin
               $error("unexpected result value_res %0d last_res %0b",
                      rsp_payload.value_res, rsp_payload.last_res);
               error_count++;
            end else begin
               if (rsp_payload.value_res !== sorted_expect[0].value_res) begin
                  $error("value_res expected %0d actual %0d",
                         sorted_expect[0].value_res, rsp_payload.value_res);
                  error_count++;
               end
               if (rsp_payload.last_res !== sorted_expect[0].last_res) begin
                  $error("last_res expected %0b actual %0b",
                         sorted_expect[0].last_res, rsp_payload.last_res);
                  error_count++;
               end
               void'(sorted_expect.pop_front());
            end
            results_checked++;
            rsp_hold = idling ? $urandom_range(0, MAX_WAIT) : 0;
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end
         rsp_stall <= (rsp_hold != 0);
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_single_items();
      test_ordered_runs();
      wait_for_drain();
      idling <= 1'b0;
      test_random_sequences(requests_sent + 20);
      idling <= 1'b1;
      test_store_overflow();
      wait_for_drain();
      test_random_sequences(ITEM_GOAL);
      wait_for_drain();
      $display("Sorted %0d sequences from %0d requests, including extremes, repeats,",
               sequences_sent, requests_sent);
      $display("ordered runs and an overflowing store; %0d results checked.",
               results_checked);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ss_pkg.sv
hw/rtl/ss_elem_store.sv
hw/rtl/ss_range_stack.sv
hw/rtl/ss_seq.sv
hw/rtl/sequence_sorter_top.sv
test/tb_sequence_sorter_top.sv
